FILE: design/rme_pkg.sv
// Shared constants, widths and the arctangent table for the rotation matrix
// to roll/pitch/yaw converter. No dependencies.
package rme_pkg;

    localparam int IN_W = 16;
    localparam int GUARD = 12;
    // Datapath width of the CORDIC vectors; covers the growth of the gain.
    localparam int XW = 31;
    // Angle accumulator width, units of 2^-20 rad.
    localparam int ZW = 25;
    localparam int ROLL_W = 16;
    localparam int PITCH_W = 15;
    localparam int YAW_W = 16;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int TAB_LEN = 24;

    localparam logic signed [ZW-1:0] HALF_PI_Z = ZW'(1647099);
    localparam int PI_OUT = 25736;
    localparam int HALF_PI_OUT = 12868;
    localparam logic [29:0] INV_GAIN = 30'd652032874;

    function automatic logic signed [ZW-1:0] atan_entry(input int unsigned idx);
        logic [20:0] v;
        case (idx)
            0: v = 21'd823550;
            1: v = 21'd486170;
            2: v = 21'd256879;
            3: v = 21'd130396;
            4: v = 21'd65451;
            5: v = 21'd32757;
            6: v = 21'd16383;
            7: v = 21'd8192;
            8: v = 21'd4096;
            9: v = 21'd2048;
            10: v = 21'd1024;
            11: v = 21'd512;
            12: v = 21'd256;
            13: v = 21'd128;
            14: v = 21'd64;
            15: v = 21'd32;
            16: v = 21'd16;
            17: v = 21'd8;
            18: v = 21'd4;
            19: v = 21'd2;
            20: v = 21'd1;
            default: v = 21'd0;
        endcase
        return ZW'(v);
    endfunction

endpackage

FILE: design/rme_cordic.sv
// Pipelined vectoring CORDIC: one register stage per iteration, plus an
// input quadrant fold and an output rounding/saturation stage. Uses rme_pkg.
module rme_cordic
    import rme_pkg::*;
#(
    parameter int STAGES = CORDIC_STAGES_DEF,
    parameter int SIDE_W = 1,
    parameter int LIMIT = PI_OUT,
    parameter int OUT_W = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     valid_in,
    input  logic signed [XW-1:0]     y_in,
    input  logic signed [XW-1:0]     x_in,
    input  logic [SIDE_W-1:0]        side_in,
    output logic                     valid_out,
    output logic signed [OUT_W-1:0]  angle_out,
    output logic signed [XW-1:0]     mag_out,
    output logic [SIDE_W-1:0]        side_out
);

    localparam logic signed [ZW-1:0] LIM_Z = ZW'(LIMIT);
    localparam logic signed [ZW-1:0] PI_Z = ZW'(PI_OUT);

    logic signed [XW-1:0] x_reg [0:STAGES];
    logic signed [XW-1:0] y_reg [0:STAGES];
    logic signed [ZW-1:0] z_reg [0:STAGES];
    logic                 v_reg [0:STAGES];
    logic                 yz_reg [0:STAGES];
    logic                 xn_reg [0:STAGES];
    logic [SIDE_W-1:0]    side_reg [0:STAGES];

    logic signed [XW-1:0] x0_next;
    logic signed [XW-1:0] y0_next;
    logic signed [ZW-1:0] z0_next;

    // A vector in the left half plane is turned by a quarter turn first.
    always_comb
    begin
        x0_next = x_in;
        y0_next = y_in;
        z0_next = '0;
        if (x_in < 0)
        begin
            if (y_in >= 0)
            begin
                x0_next = y_in;
                y0_next = -x_in;
                z0_next = HALF_PI_Z;
            end
            else
            begin
                x0_next = -y_in;
                y0_next = x_in;
                z0_next = -HALF_PI_Z;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= x0_next;
            y_reg[0] <= y0_next;
            z_reg[0] <= z0_next;
            yz_reg[0] <= (y_in == 0);
            xn_reg[0] <= (x_in < 0);
            side_reg[0] <= side_in;
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_iter
        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;
        logic signed [XW-1:0] x_next;
        logic signed [XW-1:0] y_next;
        logic signed [ZW-1:0] z_next;

        always_comb
        begin
            xs = x_reg[i] >>> i;
            ys = y_reg[i] >>> i;
            if (y_reg[i] < 0)
            begin
                x_next = x_reg[i] - ys;
                y_next = y_reg[i] + xs;
                z_next = z_reg[i] - atan_entry(i);
            end
            else
            begin
                x_next = x_reg[i] + ys;
                y_next = y_reg[i] - xs;
                z_next = z_reg[i] + atan_entry(i);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1] <= x_next;
                y_reg[i+1] <= y_next;
                z_reg[i+1] <= z_next;
                yz_reg[i+1] <= yz_reg[i];
                xn_reg[i+1] <= xn_reg[i];
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    logic signed [ZW-1:0] z_rnd;
    logic signed [ZW-1:0] z_sel;
    logic signed [ZW-1:0] z_sat;
    logic signed [OUT_W-1:0] angle_next;
    logic signed [XW-1:0] mag_next;
    logic valid_reg;
    logic signed [OUT_W-1:0] angle_reg;
    logic signed [XW-1:0] mag_reg;
    logic [SIDE_W-1:0] side_out_reg;

    // Round half up to Q3.13; a vector on the x axis gives an exact angle.
    always_comb
    begin
        z_rnd = (z_reg[STAGES] + ZW'(64)) >>> 7;
        if (yz_reg[STAGES])
        begin
            z_sel = xn_reg[STAGES] ? PI_Z : '0;
        end
        else
        begin
            z_sel = z_rnd;
        end
        if (z_sel > LIM_Z)
        begin
            z_sat = LIM_Z;
        end
        else if (z_sel < -LIM_Z)
        begin
            z_sat = -LIM_Z;
        end
        else
        begin
            z_sat = z_sel;
        end
        angle_next = OUT_W'(z_sat);
        mag_next = (x_reg[STAGES] < 0) ? '0 : x_reg[STAGES];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= v_reg[STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_reg <= angle_next;
            mag_reg <= mag_next;
            side_out_reg <= side_reg[STAGES];
        end
    end

    assign valid_out = valid_reg;
    assign angle_out = angle_reg;
    assign mag_out = mag_reg;
    assign side_out = side_out_reg;

endmodule

FILE: design/rme_mag.sv
// Two-stage multiply of the CORDIC x output by the reciprocal gain, split
// into two 15-bit partial products. Uses rme_pkg.
module rme_mag
    import rme_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 valid_in,
    input  logic signed [XW-1:0] x_in,
    input  logic [SIDE_W-1:0]    side_in,
    output logic                 valid_out,
    output logic signed [XW-1:0] mag_out,
    output logic [SIDE_W-1:0]    side_out
);

    logic [44:0] pl_reg;
    logic [44:0] ph_reg;
    logic [44:0] pl_next;
    logic [44:0] ph_next;
    logic        v1_reg;
    logic [SIDE_W-1:0] side1_reg;
    logic [59:0] sum;
    logic signed [XW-1:0] mag_next;
    logic        valid_reg;
    logic signed [XW-1:0] mag_reg;
    logic [SIDE_W-1:0] side2_reg;

    // x is never negative here and stays below 2^30.
    assign pl_next = 45'(x_in[14:0]) * 45'(INV_GAIN);
    assign ph_next = 45'(x_in[29:15]) * 45'(INV_GAIN);
    assign sum = {ph_reg, 15'd0} + 60'(pl_reg);
    assign mag_next = XW'(sum[59:30]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= valid_in;
            valid_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pl_reg <= pl_next;
            ph_reg <= ph_next;
            side1_reg <= side_in;
            mag_reg <= mag_next;
            side2_reg <= side1_reg;
        end
    end

    assign valid_out = valid_reg;
    assign mag_out = mag_reg;
    assign side_out = side2_reg;

endmodule

FILE: design/rotation_matrix_to_euler.sv
// Rotation matrix to roll, pitch and yaw: a fully pipelined converter that
// takes one beat per clock while not stalled; each result passes through the
// roll CORDIC, the gain multiply and the pitch CORDIC in series (yaw runs
// beside roll). One stall signal holds every stage at once; the input is
// stalled only while a finished result waits at the output.
// No dependencies beyond rme_pkg, rme_cordic and rme_mag.
module rotation_matrix_to_euler
    import rme_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [IN_W-1:0]    r00,
    input  logic signed [IN_W-1:0]    r10,
    input  logic signed [IN_W-1:0]    r20,
    input  logic signed [IN_W-1:0]    r21,
    input  logic signed [IN_W-1:0]    r22,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [ROLL_W-1:0]  roll,
    output logic signed [PITCH_W-1:0] pitch,
    output logic signed [YAW_W-1:0]   yaw
);

    localparam int PAD = XW - IN_W - GUARD;
    localparam int MSIDE_W = ROLL_W + YAW_W + XW;
    localparam int PSIDE_W = ROLL_W + YAW_W;

    logic en;
    logic signed [XW-1:0] r00_x;
    logic signed [XW-1:0] r10_x;
    logic signed [XW-1:0] r21_x;
    logic signed [XW-1:0] r22_x;
    logic signed [XW-1:0] nr20_x;

    logic                     roll_v;
    logic signed [ROLL_W-1:0] roll_a;
    logic signed [XW-1:0]     roll_mag;
    logic [XW-1:0]            roll_side;
    logic signed [YAW_W-1:0]  yaw_a;

    logic                 mag_v;
    logic signed [XW-1:0] mag;
    logic [MSIDE_W-1:0]   mag_side;

    logic                      p_v;
    logic signed [PITCH_W-1:0] p_a;
    logic [PSIDE_W-1:0]        p_side;

    assign en = !(out_valid && out_stall);
    assign in_stall = !en;

    assign r00_x = {{PAD{r00[IN_W-1]}}, r00, {GUARD{1'b0}}};
    assign r10_x = {{PAD{r10[IN_W-1]}}, r10, {GUARD{1'b0}}};
    assign r21_x = {{PAD{r21[IN_W-1]}}, r21, {GUARD{1'b0}}};
    assign r22_x = {{PAD{r22[IN_W-1]}}, r22, {GUARD{1'b0}}};
    assign nr20_x = -$signed({{PAD{r20[IN_W-1]}}, r20, {GUARD{1'b0}}});

    rme_cordic #(
        .STAGES (CORDIC_STAGES),
        .SIDE_W (XW),
        .LIMIT  (PI_OUT),
        .OUT_W  (ROLL_W)
    ) u_roll (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (in_valid),
        .y_in      (r21_x),
        .x_in      (r22_x),
        .side_in   (nr20_x),
        .valid_out (roll_v),
        .angle_out (roll_a),
        .mag_out   (roll_mag),
        .side_out  (roll_side)
    );

    rme_cordic #(
        .STAGES (CORDIC_STAGES),
        .SIDE_W (1),
        .LIMIT  (PI_OUT),
        .OUT_W  (YAW_W)
    ) u_yaw (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (in_valid),
        .y_in      (r10_x),
        .x_in      (r00_x),
        .side_in   (1'b0),
        .valid_out (),
        .angle_out (yaw_a),
        .mag_out   (),
        .side_out  ()
    );

    rme_mag #(
        .SIDE_W (MSIDE_W)
    ) u_mag (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (roll_v),
        .x_in      (roll_mag),
        .side_in   ({roll_a, yaw_a, roll_side}),
        .valid_out (mag_v),
        .mag_out   (mag),
        .side_out  (mag_side)
    );

    rme_cordic #(
        .STAGES (CORDIC_STAGES),
        .SIDE_W (PSIDE_W),
        .LIMIT  (HALF_PI_OUT),
        .OUT_W  (PITCH_W)
    ) u_pitch (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (mag_v),
        .y_in      (mag_side[XW-1:0]),
        .x_in      (mag),
        .side_in   (mag_side[MSIDE_W-1:XW]),
        .valid_out (p_v),
        .angle_out (p_a),
        .mag_out   (),
        .side_out  (p_side)
    );

    assign out_valid = p_v;
    assign pitch = p_a;
    assign roll = p_side[PSIDE_W-1:YAW_W];
    assign yaw = p_side[YAW_W-1:0];

    a_stall_only_on_wait: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a waiting result");

    a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (roll <= ROLL_W'(PI_OUT) && roll >= -ROLL_W'(PI_OUT)))
        else $error("roll out of range");

    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pitch <= PITCH_W'(HALF_PI_OUT) && pitch >= -PITCH_W'(HALF_PI_OUT)))
        else $error("pitch out of range");

    a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (yaw <= YAW_W'(PI_OUT) && yaw >= -YAW_W'(PI_OUT)))
        else $error("yaw out of range");

endmodule

FILE: tb/sv/rotation_matrix_to_euler_tb.sv
// Testbench for rotation_matrix_to_euler: matrix beats go in, and roll, pitch and yaw
// come out and are checked against a CORDIC angle predictor kept here.
// Depends on rme_pkg and the rotation_matrix_to_euler RTL.
`timescale 1ns / 1ps

module rotation_matrix_to_euler_tb;
    import rme_pkg::*;

    localparam int STAGES = CORDIC_STAGES_DEF;
    localparam int LATENCY = 2 * STAGES + 6;
    localparam int RANDOM_BEATS = 925;
    localparam longint PI_Q = 25736;
    localparam longint HALF_PI_Q = 12868;
    localparam longint HALF_PI_ACC = 1647099;
    localparam longint RECIP_GAIN = 652032874;
    localparam real PI_R = 3.14159265358979;

    typedef struct {
        logic signed [ROLL_W-1:0]  roll;
        logic signed [PITCH_W-1:0] pitch;
        logic signed [YAW_W-1:0]   yaw;
    } angles_t;

    typedef struct {
        logic signed [IN_W-1:0] m00, m10, m20, m21, m22;
        bit                     typed;
        angles_t                ang;
    } matrix_row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic signed [IN_W-1:0]    r00, r10, r20, r21, r22;
    logic                      out_valid;
    logic                      out_stall;
    logic signed [ROLL_W-1:0]  roll;
    logic signed [PITCH_W-1:0] pitch;
    logic signed [YAW_W-1:0]   yaw;

    angles_t     angle_q[$];
    matrix_row_t directed_rows[$];
    int          error_count;
    int          accepted_count;

    longint atan_lut[24] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
                             4096, 2048, 1024, 512, 256, 128, 64, 32,
                             16, 8, 4, 2, 1, 0, 0, 0};

    rotation_matrix_to_euler u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .r00(r00), .r10(r10), .r20(r20), .r21(r21), .r22(r22),
        .out_valid(out_valid), .out_stall(out_stall),
        .roll(roll), .pitch(pitch), .yaw(yaw)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("rotation_matrix_to_euler test failed");
        $finish;
    end

    function automatic longint vector_angle(input longint y_in, input longint x_in,
                                            output longint magnitude);
        longint x, y, z, t, xs, ys;
        bit     y_zero, x_neg;
        x = x_in;
        y = y_in;
        z = 0;
        y_zero = (y == 0);
        x_neg = (x < 0);
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y; y = -t; z = HALF_PI_ACC;
            end
            else
            begin
                x = -y; y = t; z = -HALF_PI_ACC;
            end
        end
        for (int i = 0; i < STAGES && i < 24; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y < 0)
            begin
                x = x - ys; y = y + xs; z = z - atan_lut[i];
            end
            else
            begin
                x = x + ys; y = y - xs; z = z + atan_lut[i];
            end
        end
        if (x < 0)
            x = 0;
        magnitude = (x * RECIP_GAIN) >>> 30;
        if (y_zero)
            return x_neg ? PI_Q : 0;
        return (z + 64) >>> 7;
    endfunction

    function automatic longint saturate(input longint v, input longint lim);
        return (v > lim) ? lim : ((v < -lim) ? -lim : v);
    endfunction

    function automatic angles_t predict_angles(input logic signed [IN_W-1:0] m00, m10, m20,
                                               input logic signed [IN_W-1:0] m21, m22);
        angles_t a;
        longint  mag, dummy;
        longint  g = longint'(1) << GUARD;
        a.roll  = ROLL_W'(saturate(vector_angle(m21 * g, m22 * g, mag), PI_Q));
        a.pitch = PITCH_W'(saturate(vector_angle(-(m20 * g), mag, dummy), HALF_PI_Q));
        a.yaw   = YAW_W'(saturate(vector_angle(m10 * g, m00 * g, dummy), PI_Q));
        return a;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Output side: a result beat is taken when out_valid is high and out_stall low.
    always @(posedge clk)
    begin
        angles_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (angle_q.size() == 0)
                report_mismatch("unexpected beat", roll, 0);
            else
            begin
                want = angle_q.pop_front();
                if (roll !== want.roll)
                    report_mismatch("roll", roll, want.roll);
                if (pitch !== want.pitch)
                    report_mismatch("pitch", pitch, want.pitch);
                if (yaw !== want.yaw)
                    report_mismatch("yaw", yaw, want.yaw);
            end
        end
    end

    // Receiver stall pattern, plus one long hold-off once traffic is flowing.
    initial
    begin
        int cyc;
        int mode;
        cyc = 0;
        mode = 0;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (accepted_count >= 300 && accepted_count < 310)
            begin
                out_stall <= 1'b1;
                repeat (200) @(posedge clk);
                out_stall <= 1'b0;
                wait (accepted_count >= 310);
            end
            else
            begin
                if (cyc % 97 == 0)
                    mode = $urandom_range(0, 3);
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 9) < 3);
                    2: out_stall <= (cyc % 3 == 0);
                    default: out_stall <= ($urandom_range(0, 9) < 7);
                endcase
            end
        end
    end

    task automatic add_row(input logic signed [IN_W-1:0] m00, m10, m20, m21, m22,
                           input bit typed, input int ro, input int pi_v, input int ya);
        matrix_row_t row;
        row.m00 = m00; row.m10 = m10; row.m20 = m20; row.m21 = m21; row.m22 = m22;
        row.typed = typed;
        row.ang.roll = ROLL_W'(ro);
        row.ang.pitch = PITCH_W'(pi_v);
        row.ang.yaw = YAW_W'(ya);
        directed_rows.push_back(row);
    endtask

    task automatic send_beat(input matrix_row_t row);
        r00 <= row.m00; r10 <= row.m10; r20 <= row.m20; r21 <= row.m21; r22 <= row.m22;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        angle_q.push_back(row.typed ? row.ang
                          : predict_angles(row.m00, row.m10, row.m20, row.m21, row.m22));
        accepted_count++;
    endtask

    function automatic logic signed [IN_W-1:0] random_element();
        case ($urandom_range(0, 5))
            0: return IN_W'($urandom);
            1: return IN_W'($urandom_range(0, 15)) - 16'sd8;
            2: return 16'sd0;
            3: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            4: return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
            default: return IN_W'($urandom_range(0, 32767)) - 16'sd16384;
        endcase
    endfunction

    function automatic matrix_row_t random_row();
        matrix_row_t row;
        real ph, th, ps;
        row.typed = 1'b0;
        if ($urandom_range(0, 9) < 6)
        begin
            // A proper rotation from random angles.
            ph = ($urandom_range(0, 62831) / 10000.0) - PI_R;
            th = ($urandom_range(0, 31415) / 10000.0) - PI_R / 2.0;
            ps = ($urandom_range(0, 62831) / 10000.0) - PI_R;
            row.m00 = IN_W'($rtoi(16384.0 * $cos(th) * $cos(ps)));
            row.m10 = IN_W'($rtoi(16384.0 * $cos(th) * $sin(ps)));
            row.m20 = IN_W'($rtoi(-16384.0 * $sin(th)));
            row.m21 = IN_W'($rtoi(16384.0 * $sin(ph) * $cos(th)));
            row.m22 = IN_W'($rtoi(16384.0 * $cos(ph) * $cos(th)));
        end
        else
        begin
            row.m00 = random_element(); row.m10 = random_element();
            row.m20 = random_element(); row.m21 = random_element();
            row.m22 = random_element();
        end
        return row;
    endfunction

    initial
    begin
        int burst_left;
        error_count = 0;
        accepted_count = 0;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        r00 <= '0; r10 <= '0; r20 <= '0; r21 <= '0; r22 <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero matrix, identity, roll and yaw vectors on the negative x axis, then edge cases.
        add_row(0, 0, 0, 0, 0, 1, 0, 0, 0);
        add_row(16384, 0, 0, 0, 16384, 1, 0, 0, 0);
        add_row(-16384, 0, 0, 0, -16384, 1, int'(PI_Q), 0, int'(PI_Q));
        add_row(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0, 0, 0, 0);
        add_row(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 0, 0, 0, 0);
        add_row(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 0, 0, 0, 0);
        add_row(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000, 0, 0, 0, 0);
        add_row(0, 16384, -16384, 16384, 0, 0, 0, 0, 0);
        add_row(0, -16384, 16384, -16384, 0, 0, 0, 0, 0);
        add_row(-16384, 1, 0, 1, -16384, 0, 0, 0, 0);
        add_row(-16384, -1, 0, -1, -16384, 0, 0, 0, 0);
        add_row(0, 0, 16'sh8000, 0, 0, 0, 0, 0, 0);
        add_row(0, 0, 16'sh7FFF, 0, 0, 0, 0, 0, 0);
        add_row(1, 1, -1, 1, 1, 0, 0, 0, 0);
        add_row(11585, 11585, -11585, 11585, 11585, 0, 0, 0, 0);
        add_row(-11585, -11585, 11585, -11585, 11585, 0, 0, 0, 0);
        add_row(16384, 0, 16'sh8000, 0, 16384, 0, 0, 0, 0);
        foreach (directed_rows[i])
            send_beat(directed_rows[i]);
        in_valid <= 1'b0;
        while (angle_q.size() != 0)
            @(posedge clk);

        burst_left = $urandom_range(1, 20);
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            send_beat(random_row());
            if (n == RANDOM_BEATS / 2)
            begin
                // Drain everything before going on.
                in_valid <= 1'b0;
                while (angle_q.size() != 0)
                    @(posedge clk);
            end
            else if (--burst_left == 0)
            begin
                burst_left = $urandom_range(1, 20);
                if (accepted_count < 280 || accepted_count > 320)
                begin
                    in_valid <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge clk);
                end
            end
        end
        in_valid <= 1'b0;
        while (angle_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (error_count == 0 && angle_q.size() == 0)
            $display("rotation_matrix_to_euler test passed");
        else
            $display("rotation_matrix_to_euler test failed");
        $finish;
    end

endmodule
